// ----- rtl/core/tick_position_error_and_timers_macros.svh -----
// Assertion macros used by the checker file.
`ifndef TICK_POSITION_ERROR_AND_TIMERS_MACROS_SVH
`define TICK_POSITION_ERROR_AND_TIMERS_MACROS_SVH

// Concurrent check on clk, off while rst is high.
`define TPET_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check on clk that also runs through reset.
`define TPET_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tpet_pkg.sv -----
`default_nettype none
package tpet_pkg;

  localparam int POSITION_SHIFT = 3;
  localparam int TIMER_WIDTH    = 16;
  localparam int POS_W          = 32;
  localparam int TICK_W         = 16;
  localparam int LOAD_W         = 16;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;

  // Word index of each configuration register (byte address / 4)
  localparam logic REG_SAMPLING_PERIOD = 1'b0;
  localparam logic [TICK_W-1:0] SAMPLING_PERIOD_RESET = TICK_W'(9);

  typedef enum logic [1:0] {
    MODE_TICK        = 2'd0,
    MODE_LOAD_A      = 2'd1,
    MODE_LOAD_B      = 2'd2,
    MODE_LOAD_TOGGLE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic [LOAD_W-1:0]        load_value;
    logic signed [POS_W-1:0]  position_step;
    logic [POS_W-1:0]         encoder_count;
  } item_t;

  typedef struct packed {
    logic control_ready;
    logic timeout_a;
    logic timeout_b;
    logic toggle;
  } flags_t;

  // Result of the tick stage, handed to the error stage
  typedef struct packed {
    flags_t            flags;
    logic [POS_W-1:0]  acc;
    logic [POS_W-1:0]  enc;
  } motion_t;

endpackage
`default_nettype wire

// ----- rtl/core/tick_position_error_and_timers.sv -----
// Tick-driven position error sampler with two one-shot timers and a toggle timer.
// Input channel: in_valid / in_stall carry one request per accepted edge; mode
// selects a tick or a load of one-shot A, one-shot B or the toggle period.
// Output channel: out_valid / out_stall return exactly one result per request,
// in request order: four event flags plus the latest position error and change.
// Throughput: one request per cycle unless out_stall backs up all the stages;
// a tick updates the accumulator and timers in the tick stage, the error stage
// divides and subtracts the encoder count, and the result register forms the
// change against the previous sample.
// Stall: when out_stall holds a result, each stage with a bubble still fills;
// once all three stages and the result register are full, in_stall rises.
// Reset (rst, synchronous): all stages empty, accumulator, counters and the held
// error and change go to zero, sampling_period returns to 9.
// Configuration: APB-style port, sampling_period at byte address 0. The user
// must write it only while no request is in flight; the block does not enforce it.
`default_nettype none
module tick_position_error_and_timers
  import tpet_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Request channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               mode,
  input  wire logic [LOAD_W-1:0]        load_value,
  input  wire logic signed [POS_W-1:0]  position_step,
  input  wire logic [POS_W-1:0]         encoder_count,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          control_ready,
  output logic                          timeout_a_fired,
  output logic                          timeout_b_fired,
  output logic                          toggle_fired,
  output logic signed [POS_W-1:0]       position_error_out,
  output logic signed [POS_W-1:0]       error_change,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  logic [TICK_W-1:0] sampling_period;
  logic              in_reg_valid;
  item_t             in_reg;
  logic              motion_valid;
  motion_t           motion;
  logic              err_valid;
  flags_t            out_flags;
  logic              en_in, en_motion, en_err, en_out;

  // Stage enables: a stage loads when it is empty or its successor loads
  always_comb begin
    en_out    = !out_valid || !out_stall;
    en_err    = !err_valid || en_out;
    en_motion = !motion_valid || en_err;
    en_in     = !in_reg_valid || en_motion;
    in_stall  = !en_in;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (en_in) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && in_valid) begin
      in_reg.mode          <= mode_t'(mode);
      in_reg.load_value    <= load_value;
      in_reg.position_step <= position_step;
      in_reg.encoder_count <= encoder_count;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_period <= SAMPLING_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1] == REG_SAMPLING_PERIOD)) begin
      sampling_period <= pwdata[TICK_W-1:0];
    end
  end

  always_comb begin
    pready = 1'b1;
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_SAMPLING_PERIOD) begin
      prdata = DATA_W'(sampling_period);
    end
  end

  tpet_motion u_motion (
    .clk             (clk),
    .rst             (rst),
    .en              (en_motion),
    .item_valid      (in_reg_valid),
    .item            (in_reg),
    .sampling_period (sampling_period),
    .valid           (motion_valid),
    .motion          (motion)
  );

  tpet_sample u_sample (
    .clk          (clk),
    .rst          (rst),
    .en_err       (en_err),
    .en_out       (en_out),
    .motion_valid (motion_valid),
    .motion       (motion),
    .err_valid    (err_valid),
    .out_valid    (out_valid),
    .out_flags    (out_flags),
    .last_error   (position_error_out),
    .last_change  (error_change)
  );

  always_comb begin
    control_ready   = out_flags.control_ready;
    timeout_a_fired = out_flags.timeout_a;
    timeout_b_fired = out_flags.timeout_b;
    toggle_fired    = out_flags.toggle;
  end

endmodule
`default_nettype wire

// ----- rtl/core/tpet_motion.sv -----
`default_nettype none
module tpet_motion
  import tpet_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              item_valid,
  input  wire item_t             item,
  input  wire logic [TICK_W-1:0] sampling_period,
  output logic                   valid,
  output motion_t                motion
);

  logic [TICK_W-1:0]      tick_count, tick_count_next;
  logic [POS_W-1:0]       acc, acc_next;
  logic [TIMER_WIDTH-1:0] oneshot_a, oneshot_a_next;
  logic [TIMER_WIDTH-1:0] oneshot_b, oneshot_b_next;
  logic [TIMER_WIDTH-1:0] toggle_period, toggle_period_next;
  logic [TIMER_WIDTH-1:0] toggle_count, toggle_count_next;
  flags_t                 flags, flags_next;
  logic [POS_W-1:0]       enc;

  logic [TIMER_WIDTH-1:0] load_t;
  logic [TICK_W-1:0]      tick_inc;
  logic [TIMER_WIDTH-1:0] toggle_dec;

  // Service the tick or apply the load
  always_comb begin
    load_t             = TIMER_WIDTH'(item.load_value);
    tick_inc           = tick_count + TICK_W'(1);
    toggle_dec         = toggle_count - TIMER_WIDTH'(1);
    tick_count_next    = tick_count;
    acc_next           = acc;
    oneshot_a_next     = oneshot_a;
    oneshot_b_next     = oneshot_b;
    toggle_period_next = toggle_period;
    toggle_count_next  = toggle_count;
    flags_next         = '0;
    case (item.mode)
      MODE_LOAD_A: begin
        oneshot_a_next = load_t;
      end
      MODE_LOAD_B: begin
        oneshot_b_next = load_t;
      end
      MODE_LOAD_TOGGLE: begin
        toggle_period_next = load_t;
        toggle_count_next  = load_t;
      end
      default: begin
        acc_next = acc + POS_W'(item.position_step);
        if (tick_inc > sampling_period) begin
          tick_count_next          = '0;
          flags_next.control_ready = 1'b1;
        end else begin
          tick_count_next = tick_inc;
        end
        if (oneshot_a != '0) begin
          oneshot_a_next      = oneshot_a - TIMER_WIDTH'(1);
          flags_next.timeout_a = (oneshot_a == TIMER_WIDTH'(1));
        end
        if (oneshot_b != '0) begin
          oneshot_b_next      = oneshot_b - TIMER_WIDTH'(1);
          flags_next.timeout_b = (oneshot_b == TIMER_WIDTH'(1));
        end
        if (toggle_period != '0) begin
          if (toggle_dec == '0) begin
            toggle_count_next = toggle_period;
            flags_next.toggle = 1'b1;
          end else begin
            toggle_count_next = toggle_dec;
          end
        end
      end
    endcase
  end

  // Advance the stage and commit state for each item that enters
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      tick_count    <= '0;
      acc           <= '0;
      oneshot_a     <= '0;
      oneshot_b     <= '0;
      toggle_period <= '0;
      toggle_count  <= '0;
    end else if (en) begin
      valid <= item_valid;
      if (item_valid) begin
        tick_count    <= tick_count_next;
        acc           <= acc_next;
        oneshot_a     <= oneshot_a_next;
        oneshot_b     <= oneshot_b_next;
        toggle_period <= toggle_period_next;
        toggle_count  <= toggle_count_next;
      end
    end
  end

  // Per-item payload
  always_ff @(posedge clk) begin
    if (en && item_valid) begin
      flags <= flags_next;
      enc   <= item.encoder_count;
    end
  end

  // The accumulator only moves with this stage, so it belongs to the held item
  always_comb begin
    motion.flags = flags;
    motion.acc   = acc;
    motion.enc   = enc;
  end

endmodule
`default_nettype wire

// ----- rtl/core/tpet_sample.sv -----
`default_nettype none
module tpet_sample
  import tpet_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en_err,
  input  wire logic                en_out,
  input  wire logic                motion_valid,
  input  wire motion_t             motion,
  output logic                     err_valid,
  output logic                     out_valid,
  output flags_t                   out_flags,
  output logic signed [POS_W-1:0]  last_error,
  output logic signed [POS_W-1:0]  last_change
);

  localparam logic [POS_W-1:0] ROUND_BIAS = POS_W'((1 << POSITION_SHIFT) - 1);

  logic [POS_W-1:0]        biased;
  logic signed [POS_W-1:0] quotient;
  logic signed [POS_W-1:0] err_next;
  logic signed [POS_W-1:0] err;
  flags_t                  err_flags;

  // Divide toward zero: bias negative values before the arithmetic shift
  always_comb begin
    biased   = motion.acc + (motion.acc[POS_W-1] ? ROUND_BIAS : '0);
    quotient = $signed(biased) >>> POSITION_SHIFT;
    err_next = quotient - $signed(motion.enc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid <= 1'b0;
    end else if (en_err) begin
      err_valid <= motion_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_err && motion_valid) begin
      err       <= err_next;
      err_flags <= motion.flags;
    end
  end

  // Result register: hold the last sample and its change until the next sample
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      last_error  <= '0;
      last_change <= '0;
    end else if (en_out) begin
      out_valid <= err_valid;
      if (err_valid && err_flags.control_ready) begin
        last_error  <= err;
        last_change <= err - last_error;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && err_valid) begin
      out_flags <= err_flags;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tpet_checker.sv -----
`default_nettype none
`include "tick_position_error_and_timers_macros.svh"
module tpet_checker
  import tpet_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic                     control_ready,
  input wire logic signed [POS_W-1:0]  position_error_out,
  input wire logic signed [POS_W-1:0]  error_change
);

  // Reset empties the result register
  `TPET_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

  // A stalled result holds its error value
  `TPET_ASSERT(a_stall_hold, out_valid && out_stall |=> out_valid && $stable(position_error_out), "stalled result changed")

  // The held error moves only with a delivered control sample
  `TPET_ASSERT(a_error_moves_on_sample, !$past(rst) && !$stable(position_error_out) |-> out_valid && control_ready, "error changed without a sample")

  // The change equals the step of the held error at each sample
  `TPET_ASSERT(a_change_matches, !$past(rst) && out_valid && control_ready && !$stable(error_change) |-> error_change == position_error_out - $past(position_error_out), "error change inconsistent with error")

endmodule

bind tick_position_error_and_timers tpet_checker u_tpet_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .control_ready      (control_ready),
  .position_error_out (position_error_out),
  .error_change       (error_change)
);
`default_nettype wire
